FILE: design/kmeans_1d_three_cluster_macros.svh
// Assertion helpers for the checker file.
`ifndef KMEANS_1D_THREE_CLUSTER_MACROS_SVH
`define KMEANS_1D_THREE_CLUSTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KM1D3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("km1d3 check failed");

// Next-cycle implication, checked outside reset.
`define KM1D3_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("km1d3 check failed");

`endif

FILE: design/km1d3_pkg.sv
`default_nettype none

package km1d3_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_A    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_B    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_C    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_LIMIT = 8'd3;

    localparam logic [DATA_W-1:0] RST_START_A    = 8'd35;
    localparam logic [DATA_W-1:0] RST_START_B    = 8'd42;
    localparam logic [DATA_W-1:0] RST_START_C    = 8'd49;
    localparam logic [DATA_W-1:0] RST_PASS_LIMIT = 8'd64;

    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              last_sample;
    } t_in_req;

    typedef struct packed {
        logic [DATA_W-1:0] centroid_a;
        logic [DATA_W-1:0] centroid_b;
        logic [DATA_W-1:0] centroid_c;
        logic              converged;
        logic [DATA_W-1:0] passes_used;
    } t_out_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DIV_SEL,
        S_DIV,
        S_PASS_END,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

FILE: design/kmeans_1d_three_cluster.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | i_in_valid/o_in_stall   | km1d3_pkg::t_in_req
// out     | output    | o_out_valid/i_out_stall | km1d3_pkg::t_out_rsp
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Loading takes one cycle per sample while idle (one write port of the store).
// After the last sample, each pass reads the store once and then divides each
// non-empty cluster with one shared restoring divider; an empty one is skipped
// and keeps its centroid. S_PASS_END then closes the pass.
// o_in_stall stays high from the last sample until the result is registered.
// Reset clears the count and control; the store needs no clearing pass.
// A result held by i_out_stall keeps the next one back; loading continues.
`default_nettype none

module kmeans_1d_three_cluster #(
    parameter int unsigned MAX_SAMPLES = 128
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire km1d3_pkg::t_in_req                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output km1d3_pkg::t_out_rsp                      o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [km1d3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [km1d3_pkg::DATA_W-1:0]        i_cfg_data
);

    localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SW = CW + km1d3_pkg::DATA_W;
    localparam int unsigned DW = km1d3_pkg::DATA_W;

    km1d3_pkg::t_state r_state, n_state;

    logic [DW-1:0] r_start_a, r_start_b, r_start_c, r_pass_limit;

    logic [DW-1:0] r_mem [MAX_SAMPLES];
    logic [DW-1:0] r_rd_data;
    logic          r_rd_vld;

    logic [CW-1:0] r_count;
    logic [AW-1:0] r_scan_idx;

    logic [DW-1:0] r_cen  [3];
    logic [SW-1:0] r_sum  [3];
    logic [CW-1:0] r_size [3];

    logic [1:0]    r_k;
    logic [2:0]    r_bit;
    logic [SW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic          r_changed;
    logic [DW-1:0] r_pass_cnt;
    logic          r_conv;

    logic          r_out_valid;
    km1d3_pkg::t_out_rsp r_out;

    logic          in_acc;
    logic          store_full;
    logic [AW-1:0] last_idx;
    logic [DW-1:0] da, db, dc;
    logic [1:0]    pick;
    logic [SW-1:0] trial;
    logic          take;
    logic [DW-1:0] quo_nxt;
    logic [SW-1:0] rem_nxt;
    logic [DW:0]   pass_nxt;
    logic [DW:0]   limit;
    logic          pass_stop;
    logic          out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != km1d3_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign store_full  = (r_count == CW'(MAX_SAMPLES));
    assign last_idx    = AW'(r_count - CW'(1));
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Nearest centroid; ties fall to the later cluster
    always_comb begin
        da = (r_rd_data >= r_cen[0]) ? r_rd_data - r_cen[0] : r_cen[0] - r_rd_data;
        db = (r_rd_data >= r_cen[1]) ? r_rd_data - r_cen[1] : r_cen[1] - r_rd_data;
        dc = (r_rd_data >= r_cen[2]) ? r_rd_data - r_cen[2] : r_cen[2] - r_rd_data;
        if (da < db && da < dc) begin
            pick = 2'd0;
        end else if (db < dc) begin
            pick = 2'd1;
        end else begin
            pick = 2'd2;
        end
    end

    // One restoring divide step; the mean never exceeds 8 bits
    always_comb begin
        trial   = SW'(r_size[r_k]) << r_bit;
        take    = (r_rem >= trial);
        rem_nxt = take ? r_rem - trial : r_rem;
        quo_nxt = r_quo;
        if (take) begin
            quo_nxt[r_bit] = 1'b1;
        end
    end

    always_comb begin
        pass_nxt  = {1'b0, r_pass_cnt} + (DW+1)'(1);
        limit     = (r_pass_limit == '0) ? (DW+1)'(1) : {1'b0, r_pass_limit};
        pass_stop = !r_changed || (pass_nxt >= limit);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            km1d3_pkg::S_IDLE: begin
                if (in_acc && i_in_data.last_sample) begin
                    n_state = km1d3_pkg::S_SCAN;
                end
            end
            km1d3_pkg::S_SCAN: begin
                if (r_scan_idx == last_idx) begin
                    n_state = km1d3_pkg::S_DRAIN;
                end
            end
            km1d3_pkg::S_DRAIN: n_state = km1d3_pkg::S_DIV_SEL;
            km1d3_pkg::S_DIV_SEL: begin
                if (r_size[r_k] != '0) begin
                    n_state = km1d3_pkg::S_DIV;
                end else if (r_k == 2'd2) begin
                    n_state = km1d3_pkg::S_PASS_END;
                end
            end
            km1d3_pkg::S_DIV: begin
                if (r_bit == 3'd0) begin
                    n_state = (r_k == 2'd2) ? km1d3_pkg::S_PASS_END : km1d3_pkg::S_DIV_SEL;
                end
            end
            km1d3_pkg::S_PASS_END: begin
                n_state = pass_stop ? km1d3_pkg::S_FINISH : km1d3_pkg::S_SCAN;
            end
            km1d3_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = km1d3_pkg::S_IDLE;
                end
            end
            default: n_state = km1d3_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= km1d3_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_a    <= km1d3_pkg::RST_START_A;
            r_start_b    <= km1d3_pkg::RST_START_B;
            r_start_c    <= km1d3_pkg::RST_START_C;
            r_pass_limit <= km1d3_pkg::RST_PASS_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                km1d3_pkg::CFG_START_A:    r_start_a    <= i_cfg_data;
                km1d3_pkg::CFG_START_B:    r_start_b    <= i_cfg_data;
                km1d3_pkg::CFG_START_C:    r_start_c    <= i_cfg_data;
                km1d3_pkg::CFG_PASS_LIMIT: r_pass_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sample store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc && !store_full) begin
            r_mem[r_count[AW-1:0]] <= i_in_data.sample;
        end
        r_rd_data <= r_mem[r_scan_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == km1d3_pkg::S_SCAN);
            // Count every stored sample, the last one too; drop on a full store
            if (in_acc && !store_full) begin
                r_count <= r_count + CW'(1);
            end else if (r_state == km1d3_pkg::S_FINISH && out_free) begin
                r_count <= '0;
            end
            if (r_state == km1d3_pkg::S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Start a set: load centroids and clear the pass count
        if (r_state == km1d3_pkg::S_IDLE && in_acc && i_in_data.last_sample) begin
            r_cen[0]   <= r_start_a;
            r_cen[1]   <= r_start_b;
            r_cen[2]   <= r_start_c;
            r_pass_cnt <= '0;
        end
        if (n_state == km1d3_pkg::S_SCAN && r_state != km1d3_pkg::S_SCAN) begin
            r_scan_idx <= '0;
            r_changed  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k]  <= '0;
                r_size[k] <= '0;
            end
        end else if (r_state == km1d3_pkg::S_SCAN) begin
            r_scan_idx <= r_scan_idx + AW'(1);
        end
        if (r_rd_vld) begin
            for (int k = 0; k < 3; k++) begin
                if (pick == 2'(k)) begin
                    r_sum[k]  <= r_sum[k] + SW'(r_rd_data);
                    r_size[k] <= r_size[k] + CW'(1);
                end
            end
        end
        if (r_state == km1d3_pkg::S_DRAIN) begin
            r_k <= 2'd0;
        end
        if (r_state == km1d3_pkg::S_DIV_SEL) begin
            r_rem <= r_sum[r_k];
            r_quo <= '0;
            r_bit <= 3'd7;
            // Empty cluster: keep its centroid and move on
            if (r_size[r_k] == '0) begin
                r_k <= r_k + 2'd1;
            end
        end
        if (r_state == km1d3_pkg::S_DIV) begin
            r_rem <= rem_nxt;
            r_quo <= quo_nxt;
            r_bit <= r_bit - 3'd1;
            if (r_bit == 3'd0) begin
                r_cen[r_k] <= quo_nxt;
                if (quo_nxt != r_cen[r_k]) begin
                    r_changed <= 1'b1;
                end
                r_k <= r_k + 2'd1;
            end
        end
        if (r_state == km1d3_pkg::S_PASS_END) begin
            r_pass_cnt <= pass_nxt[DW-1:0];
            r_conv     <= !r_changed;
        end
        if (r_state == km1d3_pkg::S_FINISH && out_free) begin
            r_out.centroid_a  <= r_cen[0];
            r_out.centroid_b  <= r_cen[1];
            r_out.centroid_c  <= r_cen[2];
            r_out.converged   <= r_conv;
            r_out.passes_used <= r_pass_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: design/km1d3_chk.sv
`default_nettype none
`include "kmeans_1d_three_cluster_macros.svh"

module km1d3_chk (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            o_in_stall,
    input  wire km1d3_pkg::t_in_req              i_in_data,
    input  wire logic                            o_out_valid,
    input  wire logic                            i_out_stall,
    input  wire km1d3_pkg::t_out_rsp             o_out_data
);

    // A stalled result holds
    `KM1D3_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // Every result reports at least one pass
    `KM1D3_ASSERT_IMP(a_pass_nonzero, i_clk, i_rst_n, o_out_valid, o_out_data.passes_used != 8'd0)

    // The final sample of a set starts clustering, which stalls the input
    `KM1D3_ASSERT_NXT(a_last_stalls, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_data.last_sample, o_in_stall)

    // A new result only comes out of a clustering run
    `KM1D3_ASSERT_IMP(a_rsp_after_run, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind kmeans_1d_three_cluster km1d3_chk u_km1d3_chk (.*);

`default_nettype wire
